### hdl/mbo_pkg.sv
// Package for the breakpoint oscillator: sizes, register map, config and
// command types, and the elaboration-time builders of the sine and log/exp tables.
// No dependencies.
`default_nettype none
package mbo_pkg;

  localparam int PHASE_BITS = 32;
  localparam int SINE_DEPTH = 1024;
  localparam int POW_DEPTH  = 1024;
  localparam int POW_HALF   = POW_DEPTH / 2;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int POW_AW     = $clog2(POW_DEPTH);
  localparam int HALF_AW    = POW_AW - 1;
  localparam int CFG_AW     = 5;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam logic [26:0] BASE_INC_RESET = 27'd9842633;
  localparam logic [15:0] BREAK_RESET    = 16'd32768;
  localparam logic [15:0] EXP_RESET      = 16'd16384;
  localparam logic [16:0] MORPH_RESET    = 17'd65536;

  typedef enum logic [2:0] {
    REG_PITCH_OFFSET = 3'd0,
    REG_BASE_INC     = 3'd1,
    REG_BREAKPOINT   = 3'd2,
    REG_RISE_EXP     = 3'd3,
    REG_FALL_EXP     = 3'd4,
    REG_MORPH        = 3'd5,
    REG_PHASE_OFFSET = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] pitch_offset;
    logic [26:0]        base_increment;
    logic [15:0]        breakpoint;
    logic [15:0]        rise_exponent;
    logic [15:0]        fall_exponent;
    logic [16:0]        morph;
    logic [16:0]        phase_offset;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_PITCH, OP_EXPRD, OP_MUL, OP_PHASE, OP_SPLIT, OP_DIV,
    OP_SINE, OP_BLEND_A, OP_BLEND_B, OP_LOG, OP_LPROD, OP_EXP, OP_POW, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_full;
  } stat_t;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH];
  typedef logic [15:0] pow_rom_t [POW_DEPTH];

  function automatic logic [15:0] log2_frac(input logic [63:0] m);
    logic [63:0] x;
    logic [15:0] r;
    x = m;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t   tbl;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x = (PI_HALF_Q30 * 64'(i)) / SINE_DEPTH;
      t = x;
      s = x;
      for (int n = 1; n <= 8; n++) begin
        t = ((((t * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) s = s - t;
        else s = s + t;
      end
      v = (s + 64'd8192) >> 14;
      tbl[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
    return tbl;
  endfunction

  function automatic pow_rom_t build_pow();
    pow_rom_t    tbl;
    logic [31:0] target;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    for (int k = 0; k < POW_HALF; k++) begin
      tbl[k] = log2_frac(ONE_Q30 + ((64'(k) << 30) / POW_HALF));
      target = 32'((64'(k) << 16) / POW_HALF);
      lo = '0;
      hi = 32'd65535;
      while (lo < hi) begin
        mid = (lo + hi + 32'd1) >> 1;
        if (32'(log2_frac(ONE_Q30 + (64'(mid) << 14))) <= target) lo = mid;
        else hi = mid - 32'd1;
      end
      tbl[POW_HALF + k] = lo[15:0];
    end
    return tbl;
  endfunction

endpackage
`default_nettype wire

### hdl/mbo_if.sv
// Valid/ready channel interfaces for the oscillator input and output items.
// No dependencies.
`default_nettype none
interface mbo_in_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pitch_cv_a;
  logic signed [16:0] pitch_cv_b;
  logic               reset_level;
  modport source (output valid, pitch_cv_a, pitch_cv_b, reset_level, input ready);
  modport sink (input valid, pitch_cv_a, pitch_cv_b, reset_level, output ready);
endinterface

interface mbo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface
`default_nettype wire

### hdl/mbo_regs.sv
// APB-style configuration register file.
// Depends on mbo_pkg.
`default_nettype none
module mbo_regs
  import mbo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pitch_offset   <= '0;
      cfg.base_increment <= BASE_INC_RESET;
      cfg.breakpoint     <= BREAK_RESET;
      cfg.rise_exponent  <= EXP_RESET;
      cfg.fall_exponent  <= EXP_RESET;
      cfg.morph          <= MORPH_RESET;
      cfg.phase_offset   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_PITCH_OFFSET: cfg.pitch_offset   <= pwdata[14:0];
        REG_BASE_INC:     cfg.base_increment <= pwdata[26:0];
        REG_BREAKPOINT:   cfg.breakpoint     <= pwdata[15:0];
        REG_RISE_EXP:     cfg.rise_exponent  <= pwdata[15:0];
        REG_FALL_EXP:     cfg.fall_exponent  <= pwdata[15:0];
        REG_MORPH:        cfg.morph          <= pwdata[16:0];
        REG_PHASE_OFFSET: cfg.phase_offset   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PITCH_OFFSET: prdata = {17'd0, cfg.pitch_offset};
      REG_BASE_INC:     prdata = {5'd0, cfg.base_increment};
      REG_BREAKPOINT:   prdata = {16'd0, cfg.breakpoint};
      REG_RISE_EXP:     prdata = {16'd0, cfg.rise_exponent};
      REG_FALL_EXP:     prdata = {16'd0, cfg.fall_exponent};
      REG_MORPH:        prdata = {15'd0, cfg.morph};
      REG_PHASE_OFFSET: prdata = {15'd0, cfg.phase_offset};
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hdl/mbo_ctrl.sv
// Sequencer: walks one item through the datapath steps, one step a cycle;
// the divide step repeats, a full output stalls. Depends on mbo_pkg.
`default_nettype none
module mbo_ctrl
  import mbo_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PITCH, S_EXPRD, S_MUL, S_PHASE, S_SPLIT, S_DIV, S_SINE,
    S_BLEND_A, S_BLEND_B, S_LOG, S_LPROD, S_EXP, S_POW, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_PITCH;
        end
      end
      S_PITCH:   begin cmd.op = OP_PITCH;   state_next = S_EXPRD;   end
      S_EXPRD:   begin cmd.op = OP_EXPRD;   state_next = S_MUL;     end
      S_MUL:     begin cmd.op = OP_MUL;     state_next = S_PHASE;   end
      S_PHASE:   begin cmd.op = OP_PHASE;   state_next = S_SPLIT;   end
      S_SPLIT:   begin cmd.op = OP_SPLIT;   state_next = S_DIV;     end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_next = S_SINE;
      end
      S_SINE:    begin cmd.op = OP_SINE;    state_next = S_BLEND_A; end
      S_BLEND_A: begin cmd.op = OP_BLEND_A; state_next = S_BLEND_B; end
      S_BLEND_B: begin cmd.op = OP_BLEND_B; state_next = S_LOG;     end
      S_LOG:     begin cmd.op = OP_LOG;     state_next = S_LPROD;   end
      S_LPROD:   begin cmd.op = OP_LPROD;   state_next = S_EXP;     end
      S_EXP:     begin cmd.op = OP_EXP;     state_next = S_POW;     end
      S_POW:     begin cmd.op = OP_POW;     state_next = S_OUT;     end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/mbo_dp.sv
// Datapath: phase accumulator, restoring divider, sine and log/exp ROMs,
// blend and power arithmetic, output register. Depends on mbo_pkg.
`default_nettype none
module mbo_dp
  import mbo_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire cfg_t               cfg,
  input  wire logic signed [16:0] pitch_cv_a,
  input  wire logic signed [16:0] pitch_cv_b,
  input  wire logic               reset_level,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      sample_out
);

  typedef enum logic [1:0] {SEG_NONE, SEG_RISE, SEG_FALL} seg_t;

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam pow_rom_t  POW_ROM  = build_pow();

  logic signed [16:0]  cv_a;
  logic signed [16:0]  cv_b;
  logic                rst_lvl;
  logic [15:0]         pitch_q;
  logic [43:0]         inc_prod;
  logic [PHASE_BITS-1:0] phase;
  logic                reset_prev;
  seg_t                seg;
  logic [17:0]         rem;
  logic [16:0]         dvs;
  logic [15:0]         quo;
  logic [3:0]          div_cnt;
  logic [15:0]         sine_q;
  logic                sine_top;
  logic                sine_neg;
  logic [15:0]         pow_q;
  logic [33:0]         acc;
  logic [16:0]         blend;
  logic [3:0]          p_reg;
  logic [22:0]         lprod;
  logic [16:0]         y;
  logic                y_done;

  logic signed [18:0]  pitch_sum;
  logic signed [18:0]  pitch_clamp;
  logic [53:0]         inc_sh;
  logic [PHASE_BITS-1:0] inc_ph;
  logic                edge_rst;
  logic [15:0]         x;
  logic [17:0]         rs;
  logic [16:0]         tri_v;
  logic [15:0]         w;
  logic [15:0]         e;
  logic [15:0]         u;
  logic [SINE_AW:0]    sine_idx;
  logic [16:0]         sv;
  logic [17:0]         c_sum;
  logic [16:0]         c;
  logic [16:0]         m;
  logic [34:0]         bsum;
  logic [3:0]          p;
  logic [31:0]         frac_w;
  logic [20:0]         lg;
  logic [36:0]         lmul;
  logic [15:0]         fp;
  logic [4:0]          ip;
  logic [15:0]         nfp;
  logic [16:0]         mant;
  logic [20:0]         y10;
  logic [16:0]         ysh;
  logic [POW_AW-1:0]   pow_addr;

  assign pitch_sum = 19'($signed(cfg.pitch_offset)) + 19'(cv_a) + 19'(cv_b);
  assign pitch_clamp = (pitch_sum > 19'sd20480) ? 19'sd20480 :
                       (pitch_sum < -19'sd20480) ? -19'sd20480 : pitch_sum;

  assign inc_sh   = {10'd0, inc_prod} << pitch_q[15:12];
  assign inc_ph   = inc_sh[52 -: PHASE_BITS];
  assign edge_rst = rst_lvl && !reset_prev;
  assign x        = phase[PHASE_BITS-1 -: 16];
  assign rs       = {rem[16:0], 1'b0};

  always_comb begin
    unique case (seg)
      SEG_RISE: begin
        tri_v = {1'b0, quo};
        w     = {1'b1, quo[15:1]};
        e     = cfg.rise_exponent;
      end
      SEG_FALL: begin
        tri_v = 17'(17'h10000 - {1'b0, quo});
        w     = {1'b0, quo[15:1]};
        e     = cfg.fall_exponent;
      end
      default: begin
        tri_v = '0;
        w     = '0;
        e     = '0;
      end
    endcase
  end

  assign u        = w + cfg.phase_offset[15:0];
  assign sine_idx = u[14] ? ((SINE_AW+1)'(SINE_DEPTH) - {1'b0, u[13 -: SINE_AW]})
                          : {1'b0, u[13 -: SINE_AW]};

  assign sv    = sine_top ? 17'd65535 : {1'b0, sine_q};
  assign c_sum = sine_neg ? (18'h10000 + {1'b0, sv}) : (18'h10000 - {1'b0, sv});
  assign c     = c_sum[17:1];
  assign m     = (cfg.morph > 17'd65536) ? 17'd65536 : cfg.morph;
  assign bsum  = {1'b0, acc} + 35'(tri_v * m);

  always_comb begin
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (blend[i]) p = 4'(i);
    end
  end

  assign frac_w = {16'd0, blend[15:0]} << (5'd16 - {1'b0, p});
  assign lg     = {(5'd16 - {1'b0, p_reg}), 16'd0} - {5'd0, pow_q};
  assign lmul   = 37'(lg * e);
  assign fp     = lprod[15:0];
  assign ip     = lprod[20:16];
  assign nfp    = 16'(17'h10000 - {1'b0, fp});
  assign mant   = 17'h10000 + {1'b0, pow_q};
  assign y10    = {y, 3'd0} + {2'd0, y, 1'b0};
  assign ysh    = y10[20:4];

  always_comb begin
    unique case (cmd.op)
      OP_EXPRD: pow_addr = {1'b1, pitch_q[11 -: HALF_AW]};
      OP_LOG:   pow_addr = {1'b0, frac_w[15 -: HALF_AW]};
      OP_EXP:   pow_addr = {1'b1, nfp[15 -: HALF_AW]};
      default:  pow_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    sine_q <= SINE_ROM[sine_idx[SINE_AW-1:0]];
    pow_q  <= POW_ROM[pow_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      reset_prev <= 1'b0;
      out_valid  <= 1'b0;
      div_cnt    <= '0;
      seg        <= SEG_NONE;
      y_done     <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          cv_a    <= pitch_cv_a;
          cv_b    <= pitch_cv_b;
          rst_lvl <= reset_level;
        end
        OP_PITCH: pitch_q <= 16'(pitch_clamp + 19'sd20480);
        OP_MUL:   inc_prod <= cfg.base_increment * (17'h10000 + {1'b0, pow_q});
        OP_PHASE: begin
          phase      <= edge_rst ? '0 : phase + inc_ph;
          reset_prev <= rst_lvl;
        end
        OP_SPLIT: begin
          quo     <= '0;
          div_cnt <= '0;
          if (x < cfg.breakpoint) begin
            seg <= SEG_RISE;
            rem <= {2'd0, x};
            dvs <= {1'b0, cfg.breakpoint};
          end else if (x > cfg.breakpoint) begin
            seg <= SEG_FALL;
            rem <= {2'd0, x - cfg.breakpoint};
            dvs <= 17'(17'h10000 - {1'b0, cfg.breakpoint});
          end else begin
            seg <= SEG_NONE;
            rem <= '0;
            dvs <= 17'd1;
          end
        end
        OP_DIV: begin
          div_cnt <= div_cnt + 4'd1;
          if (rs >= {1'b0, dvs}) begin
            rem <= rs - {1'b0, dvs};
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= rs;
            quo <= {quo[14:0], 1'b0};
          end
        end
        OP_SINE: begin
          sine_neg <= u[15];
          sine_top <= sine_idx[SINE_AW];
        end
        OP_BLEND_A: acc <= c * (17'h10000 - m);
        OP_BLEND_B: blend <= bsum[32:16];
        OP_LOG: begin
          p_reg <= p;
          if (e == '0 || blend[16]) begin
            y      <= 17'h10000;
            y_done <= 1'b1;
          end else if (blend == '0) begin
            y      <= '0;
            y_done <= 1'b1;
          end else begin
            y_done <= 1'b0;
          end
        end
        OP_LPROD: lprod <= lmul[36:14];
        OP_EXP: begin
          if (!y_done) begin
            if (lprod >= (23'd20 << 16)) begin
              y      <= '0;
              y_done <= 1'b1;
            end else if (fp == '0) begin
              y      <= 17'h10000 >> ip;
              y_done <= 1'b1;
            end
          end
        end
        OP_POW: begin
          if (!y_done) y <= mant >> (ip + 5'd1);
        end
        OP_OUT: sample_out <= 16'(ysh - 17'd20480);
        default: ;
      endcase
    end
  end

  assign stat.div_last = (div_cnt == 4'd15);
  assign stat.out_full = out_valid;

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PHASE && edge_rst) |=> (phase == '0))
    else $error("phase not cleared on reset edge");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_BLEND_B) |=> (blend <= 17'd65536))
    else $error("blend above one");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_POW) |=> (y <= 17'd65536))
    else $error("power above one");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> !out_valid)
    else $error("output overwritten while pending");

endmodule
`default_nettype wire

### hdl/morphing_breakpoint_oscillator.sv
// Top level of the breakpoint oscillator: config registers, sequencer, datapath.
// Depends on mbo_pkg, mbo_if, mbo_regs, mbo_ctrl, mbo_dp.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        pitch_cv_a, pitch_cv_b, reset_level
//   out_ch    out  valid/ready        sample_out
//   apb       in   psel/penable/pready paddr, pwdata, prdata
//
// The 16-step divider sets most of the time from accept to result.
// A new item is taken once the previous one has reached the output register.
// Reset is synchronous; phase and edge detector clear, registers take their defaults.
// A stalled output holds the sequencer at its last step until the result is taken.
`default_nettype none
module morphing_breakpoint_oscillator
  import mbo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  mbo_in_if.sink                 in_ch,
  mbo_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  mbo_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbo_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg),
    .pitch_cv_a  (in_ch.pitch_cv_a),
    .pitch_cv_b  (in_ch.pitch_cv_b),
    .reset_level (in_ch.reset_level),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sample_out  (out_ch.sample_out)
  );

endmodule
`default_nettype wire

### test/morphing_breakpoint_oscillator_tb.sv
// Testbench for the breakpoint oscillator: directed table, then random items under
// random idling, each result checked against an in-bench predictor or a fixed expected value.
// Depends on mbo_pkg, mbo_if and the morphing_breakpoint_oscillator top level.
`timescale 1ns / 100ps
module morphing_breakpoint_oscillator_tb;
  import mbo_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mbo_in_if  in_ch ();
  mbo_out_if out_ch ();

  morphing_breakpoint_oscillator dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0] quarter_sine [SINE_DEPTH];
  logic [15:0] logexp_rom [POW_DEPTH];
  logic [14:0] knob_pitch;
  logic [26:0] step_base;
  logic [15:0] split_pt;
  logic [15:0] exp_rise;
  logic [15:0] exp_fall;
  logic [16:0] shape_mix;
  logic [16:0] sine_shift;
  logic [31:0] osc_phase;
  logic        prev_level;

  logic signed [15:0] sample_fifo [$];
  int errors = 0;
  int results_seen = 0;

  typedef struct {
    bit       is_cfg;
    reg_idx_t idx;
    int       val;
    int       cv_a;
    int       cv_b;
    bit       level;
    bit       typed;
    int       want;
  } row_t;
  row_t plan [$];

  function automatic logic [15:0] frac_log2(input logic [63:0] m);
    logic [63:0] acc;
    logic [15:0] bits;
    acc = m;
    bits = '0;
    for (int i = 15; i >= 0; i--) begin
      acc = (acc * acc) >> 30;
      if (acc >= (64'd2 << 30)) begin
        acc = acc >> 1;
        bits[i] = 1'b1;
      end
    end
    return bits;
  endfunction

  task automatic fill_tables();
    logic [63:0] xa, term, total, rnd;
    logic [31:0] goal, lo, hi, mid;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      xa = (64'd1686629713 * 64'(i)) / SINE_DEPTH;
      term = xa;
      total = xa;
      for (int n = 1; n <= 8; n++) begin
        term = ((((term * xa) >> 30) * xa) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) total = total - term;
        else total = total + term;
      end
      rnd = (total + 64'd8192) >> 14;
      quarter_sine[i] = (rnd > 64'd65535) ? 16'hFFFF : rnd[15:0];
    end
    for (int k = 0; k < POW_HALF; k++) begin
      logexp_rom[k] = frac_log2((64'd1 << 30) + ((64'(k) << 30) / POW_HALF));
      goal = 32'((64'(k) << 16) / POW_HALF);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (32'(frac_log2((64'd1 << 30) + (64'(mid) << 14))) <= goal) lo = mid;
        else hi = mid - 1;
      end
      logexp_rom[POW_HALF + k] = lo[15:0];
    end
  endtask

  function automatic int signed_sine(input logic [15:0] u);
    logic [1:0] quad;
    int j, mag;
    quad = u[15:14];
    j = (int'(u[13:0]) * SINE_DEPTH) >> 14;
    if (quad[0]) j = SINE_DEPTH - j;
    mag = (j >= SINE_DEPTH) ? 65535 : int'(quarter_sine[j]);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic longint raise_power(input longint blend, input longint ex);
    longint p, fr, ix, lg, prod, ip, fp, mant;
    if (ex == 0 || blend >= 65536) return 65536;
    if (blend == 0) return 0;
    p = 0;
    while (p < 15 && (blend >> (p + 1)) != 0) p++;
    fr = (blend << (16 - p)) & 16'hFFFF;
    ix = (fr * POW_HALF) >> 16;
    lg = (16 - p) * 65536 - longint'(logexp_rom[ix]);
    prod = (lg * ex) >> 14;
    if (prod >= (64'd20 << 16)) return 0;
    ip = prod >> 16;
    fp = prod & 16'hFFFF;
    if (fp == 0) return 65536 >> ip;
    ix = ((65536 - fp) * POW_HALF) >> 16;
    mant = 65536 + longint'(logexp_rom[POW_HALF + ix]);
    return mant >> (ip + 1);
  endfunction

  function automatic logic signed [15:0] next_sample(input logic [16:0] a, input logic [16:0] b,
                                                     input logic lvl);
    longint pitch, q, oct, fr, mult, inc, x, tri_v, w, ex, c, mx, blend, y, r, f, bp;
    pitch = longint'($signed(knob_pitch)) + longint'($signed(a)) + longint'($signed(b));
    if (pitch > 20480) pitch = 20480;
    if (pitch < -20480) pitch = -20480;
    q = pitch + 20480;
    oct = q >> 12;
    fr = q & 4095;
    mult = 65536 + longint'(logexp_rom[POW_HALF + ((fr * POW_HALF) >> 12)]);
    inc = ((longint'(step_base) * mult) << oct) >> 21;
    if (lvl && !prev_level) osc_phase = '0;
    else osc_phase = osc_phase + inc[31:0];
    prev_level = lvl;
    x = osc_phase[31:16];
    bp = split_pt;
    if (x < bp) begin
      r = (x << 16) / bp;
      tri_v = r;
      w = (r >> 1) + 32768;
      ex = exp_rise;
    end else if (x > bp) begin
      f = ((x - bp) << 16) / (65536 - bp);
      tri_v = 65536 - f;
      w = f >> 1;
      ex = exp_fall;
    end else begin
      tri_v = 0;
      w = 0;
      ex = 0;
    end
    c = (65536 - longint'(signed_sine(16'((w + sine_shift) & 16'hFFFF)))) >> 1;
    mx = (shape_mix > 65536) ? 65536 : shape_mix;
    blend = (c * (65536 - mx) + tri_v * mx) >> 16;
    y = raise_power(blend, ex);
    return 16'(((10 * y) >> 4) - 20480);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sample_fifo.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = CFG_AW'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PITCH_OFFSET: knob_pitch = val[14:0];
      REG_BASE_INC:     step_base = val[26:0];
      REG_BREAKPOINT:   split_pt = val[15:0];
      REG_RISE_EXP:     exp_rise = val[15:0];
      REG_FALL_EXP:     exp_fall = val[15:0];
      REG_MORPH:        shape_mix = val[16:0];
      REG_PHASE_OFFSET: sine_shift = val[16:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_tick(input logic [16:0] a, input logic [16:0] b, input logic lvl,
                           input bit typed, input int want);
    int gap;
    logic signed [15:0] pred;
    gap = $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.pitch_cv_a = a;
    in_ch.pitch_cv_b = b;
    in_ch.reset_level = lvl;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pred = next_sample(a, b, lvl);
    sample_fifo.push_back(typed ? 16'(want) : pred);
  endtask

  function automatic logic [31:0] pick_reg(input reg_idx_t idx);
    int mode;
    mode = $urandom_range(0, 3);
    case (idx)
      REG_PITCH_OFFSET: return mode == 0 ? 32'h4000 : mode == 1 ? 32'h3FFF :
                               32'($urandom_range(0, 32767));
      REG_BASE_INC:     return mode == 0 ? 32'd1 : mode == 1 ? 32'h7FFFFFF :
                               32'($urandom_range(1, 32'h7FFFFFF));
      REG_BREAKPOINT:   return mode == 0 ? 32'd7 : mode == 1 ? 32'd65529 :
                               32'($urandom_range(0, 65535));
      REG_RISE_EXP, REG_FALL_EXP:
                        return mode == 0 ? 32'd0 : mode == 1 ? 32'd32768 :
                               32'($urandom_range(0, 65535));
      default:          return mode == 0 ? 32'd0 : mode == 1 ? 32'd65536 :
                               32'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [16:0] pick_cv();
    if ($urandom_range(0, 9) == 0) return 17'($urandom());
    return 17'($signed($urandom_range(0, 81920)) - 40960);
  endfunction

  task automatic add_cfg(input reg_idx_t idx, input int val);
    row_t r;
    r = '{idx: REG_PITCH_OFFSET, default: 0};
    r.is_cfg = 1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endtask

  task automatic add_tick(input int a, input int b, input bit lvl, input bit typed,
                          input int want);
    row_t r;
    r = '{idx: REG_PITCH_OFFSET, default: 0};
    r.cv_a = a;
    r.cv_b = b;
    r.level = lvl;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endtask

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random back-pressure, one long hold-off
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (sample_fifo.size() == 0) begin
          report_mismatch("unexpected sample_out", out_ch.sample_out, 0);
        end else begin
          if (out_ch.sample_out !== sample_fifo[0])
            report_mismatch("sample_out", out_ch.sample_out, sample_fifo[0]);
          void'(sample_fifo.pop_front());
        end
        results_seen++;
        hold = (results_seen == 400) ? 500 : $urandom_range(0, 6);
        if (results_seen > 900 && results_seen < 1000) hold = 0;
      end
      @(negedge clk);
      out_ch.ready = (hold == 0);
      if (hold > 0) hold--;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pitch_cv_a = '0;
    in_ch.pitch_cv_b = '0;
    in_ch.reset_level = 1'b0;
    fill_tables();
    knob_pitch = '0;
    step_base = BASE_INC_RESET;
    split_pt = BREAK_RESET;
    exp_rise = EXP_RESET;
    exp_fall = EXP_RESET;
    shape_mix = MORPH_RESET;
    sine_shift = '0;
    osc_phase = '0;
    prev_level = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_tick(0, 0, 1, 1, -20480);
    add_tick(40960, 40960, 1, 0, 0);
    add_tick(-40960, -40960, 0, 0, 0);
    add_tick(40960, -40960, 0, 0, 0);
    add_tick(65535, -65536, 0, 0, 0);
    add_cfg(REG_BREAKPOINT, 0);
    add_tick(0, 0, 1, 1, 20480);
    add_tick(12000, 0, 0, 0, 0);
    add_cfg(REG_RISE_EXP, 0);
    add_cfg(REG_BREAKPOINT, 7);
    add_tick(0, 0, 1, 1, 20480);
    add_tick(0, 0, 0, 0, 0);
    add_cfg(REG_MORPH, 0);
    add_cfg(REG_FALL_EXP, 32768);
    add_cfg(REG_BREAKPOINT, 65529);
    add_cfg(REG_PHASE_OFFSET, 131071);
    add_tick(40960, 40960, 0, 0, 0);
    add_tick(20000, 0, 0, 0, 0);
    add_cfg(REG_MORPH, 131071);
    add_cfg(REG_PITCH_OFFSET, 16383);
    add_cfg(REG_BASE_INC, 134217727);
    add_tick(40960, 40960, 0, 0, 0);
    add_tick(-40960, 0, 0, 0, 0);
    add_cfg(REG_PITCH_OFFSET, 16384);
    add_tick(0, 0, 0, 0, 0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_and_settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_tick(17'(plan[i].cv_a), 17'(plan[i].cv_b), plan[i].level, plan[i].typed,
                  plan[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_settle();
      @(negedge clk);
      in_ch.valid = 1'b0;
      for (int r = 0; r < 7; r++) write_reg(reg_idx_t'(r), pick_reg(reg_idx_t'(r)));
      for (int n = 0; n < 230; n++)
        send_tick(pick_cv(), pick_cv(), $urandom_range(0, 19) == 0, 0, 0);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (sample_fifo.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
